// ----- sv/ascii_command_frame_parser_assert.svh -----
// assertion macros shared by the command frame parser
`ifndef ASCII_COMMAND_FRAME_PARSER_ASSERT_SVH
`define ASCII_COMMAND_FRAME_PARSER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ACFP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ACFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/acfp_pkg.sv -----
// shared types and constants of the command frame parser
package acfp_pkg;

   localparam int LINE_MAX = 128;
   localparam int LEN_W = $clog2(LINE_MAX);
   localparam int NFIELDS = 6;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_NUL    = 8'h00;

   localparam logic [31:0] DAC_MAX    = 32'd65535;
   localparam logic [31:0] POWER_MAX  = 32'd1000;
   localparam logic [31:0] TIME_MAX   = 32'd1000000;

   typedef enum logic [3:0] {
      ERR_NONE        = 4'd0,
      ERR_OVERFLOW    = 4'd1,
      ERR_FRAME       = 4'd2,
      ERR_CS_FORMAT   = 4'd3,
      ERR_CS_MISMATCH = 4'd4,
      ERR_EMPTY       = 4'd5,
      ERR_ARM_ARG     = 4'd6,
      ERR_PING_ARG    = 4'd7,
      ERR_SHOT_COUNT  = 4'd8,
      ERR_SHOT_FORMAT = 4'd9,
      ERR_DISARMED    = 4'd10,
      ERR_SHOT_RANGE  = 4'd11,
      ERR_UNKNOWN     = 4'd12
   } err_type;

   typedef enum logic [3:0] {
      CM_START = 4'd0,
      CM_A     = 4'd1,
      CM_AR    = 4'd2,
      CM_ARM   = 4'd3,
      CM_P     = 4'd4,
      CM_PI    = 4'd5,
      CM_PIN   = 4'd6,
      CM_PING  = 4'd7,
      CM_S     = 4'd8,
      CM_SH    = 4'd9,
      CM_SHO   = 4'd10,
      CM_SHOT  = 4'd11,
      CM_DEAD  = 4'd15
   } cm_type;

   typedef struct packed {
      logic [LEN_W-1:0]              length;
      logic                          nul_seen;
      logic                          starts_with_dollar;
      logic                          star_seen;
      logic                          star_right_after_dollar;
      logic [7:0]                    payload_xor;
      logic [1:0]                    hex_digit_count;
      logic [7:0]                    hex_value;
      logic                          hex_bad;
      logic [3:0]                    token_index;
      logic                          in_token;
      cm_type                        command_match;
      logic [NFIELDS-1:0][31:0]      field_value;
      logic [NFIELDS-1:0]            field_digits_only;
   } line_type;

   typedef struct packed {
      logic        is_error;
      err_type     error_code;
      logic [31:0] seq;
      logic        shot_go;
      logic [15:0] dac_x;
      logic [15:0] dac_y;
      logic [19:0] settle_delay;
      logic [19:0] fire_us;
      logic [9:0]  power_level;
   } result_type;

   typedef struct packed {
      logic       has_result;
      result_type result;
      logic       arm_write;
      logic       arm_value;
   } verdict_type;

   function automatic cm_type match_next(cm_type s, logic [7:0] c);
      cm_type n;
      n = CM_DEAD;
      unique case (s)
         CM_START: begin
            if (c == "A") n = CM_A;
            else if (c == "P") n = CM_P;
            else if (c == "S") n = CM_S;
         end
         CM_A:   if (c == "R") n = CM_AR;
         CM_AR:  if (c == "M") n = CM_ARM;
         CM_P:   if (c == "I") n = CM_PI;
         CM_PI:  if (c == "N") n = CM_PIN;
         CM_PIN: if (c == "G") n = CM_PING;
         CM_S:   if (c == "H") n = CM_SH;
         CM_SH:  if (c == "O") n = CM_SHO;
         CM_SHO: if (c == "T") n = CM_SHOT;
         default: n = CM_DEAD;
      endcase
      return n;
   endfunction

endpackage

// ----- sv/acfp_line.sv -----
// per-line parsing state: framing, checksum, tokens and decimal fields
module acfp_line (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        rx_byte,
   output acfp_pkg::line_type line_state
);
   import acfp_pkg::*;

   line_type line_ff, line_in;
   line_type line_clear;

   logic [LEN_W-1:0] pos;
   logic [3:0]       tok;
   logic [3:0]       digit;
   logic             is_digit;
   logic             hex_ok;
   logic [3:0]       hex_d;
   logic [35:0]      prod;
   logic [2:0]       fidx;

   always_comb begin
      line_clear = '0;
      line_clear.field_digits_only = '1;
   end

   always_comb begin
      line_in  = line_ff;
      pos      = line_ff.length;
      tok      = line_ff.token_index;
      digit    = rx_byte[3:0];
      is_digit = (rx_byte >= "0") && (rx_byte <= "9");
      hex_ok   = 1'b1;
      hex_d    = rx_byte[3:0];
      prod     = '0;
      fidx     = '0;
      if (is_digit) hex_d = rx_byte[3:0];
      else if ((rx_byte >= "a" && rx_byte <= "f") || (rx_byte >= "A" && rx_byte <= "F"))
         hex_d = rx_byte[3:0] + 4'd9;
      else hex_ok = 1'b0;

      if (rx_byte == CH_CR) begin
         line_in = line_ff;
      end else if (rx_byte == CH_LF || line_ff.length >= LEN_W'(LINE_MAX - 1)) begin
         line_in = line_clear;
      end else begin
         line_in.length = line_ff.length + LEN_W'(1);
         if (line_ff.nul_seen) begin
         end else if (rx_byte == CH_NUL) begin
            line_in.nul_seen = 1'b1;
         end else if (pos == '0) begin
            line_in.starts_with_dollar = (rx_byte == CH_DOLLAR);
         end else if (!line_ff.starts_with_dollar) begin
         end else if (!line_ff.star_seen) begin
            if (rx_byte == CH_STAR) begin
               line_in.star_seen = 1'b1;
               line_in.star_right_after_dollar = (pos == LEN_W'(1));
            end else begin
               line_in.payload_xor = line_ff.payload_xor ^ rx_byte;
               if (rx_byte == CH_COMMA) begin
                  line_in.in_token = 1'b0;
               end else begin
                  if (!line_ff.in_token) begin
                     line_in.in_token = 1'b1;
                     if (tok < 4'd8) tok = tok + 4'd1;
                     line_in.token_index = tok;
                  end
                  if (tok == 4'd1) begin
                     line_in.command_match = match_next(line_ff.command_match, rx_byte);
                  end else if (tok >= 4'd2 && tok <= 4'd7) begin
                     fidx = 3'(tok - 4'd2);
                     if (is_digit) begin
                        // value * 10 + digit, saturating at all ones
                        prod = ({4'b0, line_ff.field_value[fidx]} << 3)
                             + ({4'b0, line_ff.field_value[fidx]} << 1)
                             + {32'b0, digit};
                        line_in.field_value[fidx] =
                           (prod[35:32] != 4'b0) ? 32'hFFFF_FFFF : prod[31:0];
                     end else begin
                        line_in.field_digits_only[fidx] = 1'b0;
                     end
                  end
               end
            end
         end else if (line_ff.hex_digit_count < 2'd2) begin
            if (!hex_ok) begin
               line_in.hex_bad = 1'b1;
               line_in.hex_digit_count = 2'd2;
            end else begin
               line_in.hex_value = {line_ff.hex_value[3:0], hex_d};
               line_in.hex_digit_count = line_ff.hex_digit_count + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= line_clear;
      end else if (fire) begin
         line_ff <= line_in;
      end
   end

   assign line_state = line_ff;

endmodule

// ----- sv/acfp_verdict.sv -----
// end-of-line checks and command execution
module acfp_verdict (
   input  logic                 armed,
   input  logic [7:0]           rx_byte,
   input  acfp_pkg::line_type   line_state,
   output acfp_pkg::verdict_type verdict
);
   import acfp_pkg::*;

   line_type   l;
   result_type r;

   always_comb begin
      l = line_state;
      r = '0;
      verdict = '0;
      if (rx_byte == CH_CR) begin
      end else if (rx_byte != CH_LF) begin
         if (l.length >= LEN_W'(LINE_MAX - 1)) begin
            verdict.has_result = 1'b1;
            r.is_error = 1'b1;
            r.error_code = ERR_OVERFLOW;
         end
      end else if (l.length != '0 && l.starts_with_dollar) begin
         verdict.has_result = 1'b1;
         r.is_error = 1'b1;
         priority if (!l.star_seen || l.star_right_after_dollar) r.error_code = ERR_FRAME;
         else if (l.hex_bad || l.hex_digit_count < 2'd2) r.error_code = ERR_CS_FORMAT;
         else if (l.hex_value != l.payload_xor) r.error_code = ERR_CS_MISMATCH;
         else if (l.token_index == 4'd0) r.error_code = ERR_EMPTY;
         else if (l.command_match == CM_ARM) begin
            if (l.token_index < 4'd2 || !l.field_digits_only[0]) r.error_code = ERR_ARM_ARG;
            else begin
               r.is_error = 1'b0;
               verdict.arm_write = 1'b1;
               verdict.arm_value = (l.field_value[0] != 32'd0);
            end
         end else if (l.command_match == CM_PING) begin
            if (l.token_index < 4'd2 || !l.field_digits_only[0]) r.error_code = ERR_PING_ARG;
            else begin
               r.is_error = 1'b0;
               r.seq = l.field_value[0];
            end
         end else if (l.command_match == CM_SHOT) begin
            priority if (l.token_index < 4'd7) r.error_code = ERR_SHOT_COUNT;
            else if (l.field_digits_only != '1) r.error_code = ERR_SHOT_FORMAT;
            else if (!armed) begin
               r.error_code = ERR_DISARMED;
               r.seq = l.field_value[0];
            end else if (l.field_value[1] > DAC_MAX || l.field_value[2] > DAC_MAX ||
                         l.field_value[5] > POWER_MAX || l.field_value[3] > TIME_MAX ||
                         l.field_value[4] > TIME_MAX) begin
               r.error_code = ERR_SHOT_RANGE;
               r.seq = l.field_value[0];
            end else begin
               r.is_error = 1'b0;
               r.seq = l.field_value[0];
               r.shot_go = 1'b1;
               r.dac_x = l.field_value[1][15:0];
               r.dac_y = l.field_value[2][15:0];
               r.settle_delay = l.field_value[3][19:0];
               r.fire_us = l.field_value[4][19:0];
               r.power_level = l.field_value[5][9:0];
            end
         end else r.error_code = ERR_UNKNOWN;
      end
      verdict.result = r;
   end

endmodule

// ----- sv/ascii_command_frame_parser.sv -----
// Command frame parser top level. One received byte per request; each byte is
// registered, then parsed into the per-line state and, on the newline of a line
// that starts with a dollar sign or on an overflow, into a result register.
// Throughput is one byte per clock while the result side keeps up; a result
// passes the input byte register and then the result register on its way to
// the output. Reset clears all line state and the armed flag at once.
module ascii_command_frame_parser (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,    // rx_byte[7:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [119:0]  rsp_tdata,    // error_code, seq, shot_go, dac_x, dac_y,
                                       // settle_delay, fire_us, power_level, pad
   output logic          rsp_tuser     // is_error
);
   import acfp_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;
   logic        armed_ff, armed_in;
   logic        advance, fire;
   line_type    line_state;
   verdict_type verdict;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   acfp_line u_line (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .rx_byte    (in_byte_ff),
      .line_state (line_state)
   );

   acfp_verdict u_verdict (
      .armed      (armed_ff),
      .rx_byte    (in_byte_ff),
      .line_state (line_state),
      .verdict    (verdict)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (fire) in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (fire && verdict.has_result) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      armed_in = armed_ff;
      if (fire && verdict.arm_write) armed_in = verdict.arm_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         armed_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         armed_ff     <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_byte_ff <= req_tdata;
      if (fire && verdict.has_result) rsp_ff <= verdict.result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.is_error;
   assign rsp_tdata  = {1'b0, rsp_ff.power_level, rsp_ff.fire_us, rsp_ff.settle_delay,
                        rsp_ff.dac_y, rsp_ff.dac_x, rsp_ff.shot_go, rsp_ff.seq,
                        rsp_ff.error_code};

`include "ascii_command_frame_parser_assert.svh"

   `ACFP_ASSERT_IMPL(a_go_not_error, clock, reset, rsp_valid_ff && rsp_ff.shot_go, !rsp_ff.is_error)
   `ACFP_ASSERT_IMPL(a_error_has_code, clock, reset, rsp_valid_ff, rsp_ff.is_error == (rsp_ff.error_code != ERR_NONE))
   `ACFP_ASSERT_NEXT(a_arm_only_by_command, clock, reset, !(fire && verdict.arm_write), armed_ff == $past(armed_ff))

endmodule

// ----- verif/tb_top.sv -----
// testbench of the command frame parser: framed byte stream in, checked results out
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import acfp_pkg::*;

   // expected results of the parser, worked out per byte as it is accepted
   class frame_checker;
      bit          armed;
      int unsigned line_len;
      bit          dollar_first, star_seen, star_first, nul_seen;
      logic [7:0]  running_xor, cs_value;
      int unsigned cs_digits;
      bit          cs_bad;
      int unsigned tok_count;
      bit          in_tok;
      string       cmd_name;
      logic [31:0] fval[NFIELDS];
      bit          fdigits[NFIELDS];
      result_type  outstanding[$];
      int          mismatches;
      int          checked;
      int          shots_fired;

      function void clear_line();
         line_len = 0;
         dollar_first = 0;
         star_seen = 0;
         star_first = 0;
         nul_seen = 0;
         running_xor = '0;
         cs_value = '0;
         cs_digits = 0;
         cs_bad = 0;
         tok_count = 0;
         in_tok = 0;
         cmd_name = "";
         for (int i = 0; i < NFIELDS; i++) begin
            fval[i] = '0;
            fdigits[i] = 1;
         end
      endfunction

      function void reset_all();
         armed = 0;
         clear_line();
      endfunction

      function void push(bit e, err_type code, logic [31:0] s);
         result_type r;
         r = '0;
         r.is_error = e;
         r.error_code = code;
         r.seq = s;
         outstanding.push_back(r);
      endfunction

      function int hex_digit(logic [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return -1;
      endfunction

      function void payload_char(logic [7:0] c);
         int unsigned f;
         logic [63:0] v;
         running_xor ^= c;
         if (c == CH_COMMA) begin
            in_tok = 0;
            return;
         end
         if (!in_tok) begin
            in_tok = 1;
            if (tok_count < 8) tok_count++;
         end
         if (tok_count == 1) begin
            // names longer than any command can never match
            if (cmd_name.len() < 5) cmd_name = {cmd_name, string'(c)};
         end else if (tok_count >= 2 && tok_count <= 7) begin
            f = tok_count - 2;
            if (c >= "0" && c <= "9") begin
               v = 64'(fval[f]) * 10 + 64'(c - "0");
               fval[f] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
            end else begin
               fdigits[f] = 0;
            end
         end
      endfunction

      function void store_char(logic [7:0] c);
         int unsigned pos;
         int d;
         pos = line_len;
         line_len++;
         if (nul_seen) return;
         if (c == CH_NUL) begin
            nul_seen = 1;
            return;
         end
         if (pos == 0) begin
            dollar_first = (c == CH_DOLLAR);
            return;
         end
         if (!dollar_first) return;
         if (!star_seen) begin
            if (c == CH_STAR) begin
               star_seen = 1;
               star_first = (pos == 1);
            end else begin
               payload_char(c);
            end
            return;
         end
         if (cs_digits < 2) begin
            d = hex_digit(c);
            if (d < 0) begin
               cs_bad = 1;
               cs_digits = 2;
            end else begin
               cs_value = {cs_value[3:0], 4'(d)};
               cs_digits++;
            end
         end
      endfunction

      function void finish_line();
         bit fmt_ok;
         result_type r;
         if (!dollar_first) return;
         if (!star_seen || star_first) push(1, ERR_FRAME, 0);
         else if (cs_bad || cs_digits < 2) push(1, ERR_CS_FORMAT, 0);
         else if (cs_value != running_xor) push(1, ERR_CS_MISMATCH, 0);
         else if (tok_count == 0) push(1, ERR_EMPTY, 0);
         else if (cmd_name == "ARM") begin
            if (tok_count < 2 || !fdigits[0]) push(1, ERR_ARM_ARG, 0);
            else begin
               armed = (fval[0] != 0);
               push(0, ERR_NONE, 0);
            end
         end else if (cmd_name == "PING") begin
            if (tok_count < 2 || !fdigits[0]) push(1, ERR_PING_ARG, 0);
            else push(0, ERR_NONE, fval[0]);
         end else if (cmd_name == "SHOT") begin
            fmt_ok = 1;
            for (int i = 0; i < NFIELDS; i++) if (!fdigits[i]) fmt_ok = 0;
            if (tok_count < 7) push(1, ERR_SHOT_COUNT, 0);
            else if (!fmt_ok) push(1, ERR_SHOT_FORMAT, 0);
            else if (!armed) push(1, ERR_DISARMED, fval[0]);
            else if (fval[1] > DAC_MAX || fval[2] > DAC_MAX || fval[5] > POWER_MAX ||
                     fval[3] > TIME_MAX || fval[4] > TIME_MAX)
               push(1, ERR_SHOT_RANGE, fval[0]);
            else begin
               r = '0;
               r.seq = fval[0];
               r.shot_go = 1;
               r.dac_x = fval[1][15:0];
               r.dac_y = fval[2][15:0];
               r.settle_delay = fval[3][19:0];
               r.fire_us = fval[4][19:0];
               r.power_level = fval[5][9:0];
               outstanding.push_back(r);
            end
         end else push(1, ERR_UNKNOWN, 0);
      endfunction

      function void note_byte(logic [7:0] c);
         if (c == CH_CR) return;
         if (c == CH_LF) begin
            if (line_len == 0) return;
            finish_line();
            clear_line();
            return;
         end
         if (line_len >= LINE_MAX - 1) begin
            clear_line();
            push(1, ERR_OVERFLOW, 0);
            return;
         end
         store_char(c);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch in result %0d: %s got %0h expected %0h", checked, what, got, want);
         mismatches++;
      endtask

      task check_result(result_type got);
         result_type exp;
         checked++;
         if (outstanding.size() == 0) begin
            report("unexpected result, error_code", got.error_code, 0);
            return;
         end
         exp = outstanding.pop_front();
         if (exp.shot_go) shots_fired++;
         if (got.is_error != exp.is_error) report("is_error", got.is_error, exp.is_error);
         if (got.error_code != exp.error_code)
            report("error_code", got.error_code, exp.error_code);
         if (got.seq != exp.seq) report("seq", got.seq, exp.seq);
         if (got.shot_go != exp.shot_go) report("shot_go", got.shot_go, exp.shot_go);
         if (got.dac_x != exp.dac_x) report("dac_x", got.dac_x, exp.dac_x);
         if (got.dac_y != exp.dac_y) report("dac_y", got.dac_y, exp.dac_y);
         if (got.settle_delay != exp.settle_delay)
            report("settle_delay", got.settle_delay, exp.settle_delay);
         if (got.fire_us != exp.fire_us) report("fire_us", got.fire_us, exp.fire_us);
         if (got.power_level != exp.power_level)
            report("power_level", got.power_level, exp.power_level);
      endtask
   endclass

   localparam int CYCLE_LIMIT = 600000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [119:0] rsp_tdata;
   logic         rsp_tuser;

   frame_checker expected;
   int           bytes_sent;
   int           lines_sent;
   bit           hold_off;
   int unsigned  cycle_count;

   ascii_command_frame_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one, sometimes none for a while
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task send_byte(logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected.note_byte(b);
      bytes_sent++;
   endtask

   task send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      lines_sent++;
   endtask

   function string hex_pair(logic [7:0] v);
      string h;
      h = $sformatf("%02x", v);
      if ($urandom_range(0, 1)) h = h.toupper();
      return h;
   endfunction

   function logic [7:0] xor_of(string s);
      logic [7:0] x;
      x = '0;
      for (int i = 0; i < s.len(); i++) x ^= s[i];
      return x;
   endfunction

   // well-formed frame around a payload, optional CR before the newline
   function string frame(string payload);
      string f;
      f = {"$", payload, "*", hex_pair(xor_of(payload))};
      if ($urandom_range(0, 3) == 0) f = {f, "\r"};
      return {f, "\n"};
   endfunction

   function string rand_number();
      case ($urandom_range(0, 7))
         0: return "0";
         1: return "4294967295";
         2: return "99999999999";
         3: return $sformatf("%0d", $urandom);
         default: return $sformatf("%0d", $urandom_range(0, 999));
      endcase
   endfunction

   function string shot_payload(bit in_range);
      string p;
      p = {"SHOT,", rand_number()};
      if (in_range) begin
         p = {p, $sformatf(",%0d,%0d", $urandom_range(0, 65535), $urandom_range(0, 65535))};
         p = {p, $sformatf(",%0d,%0d,%0d", $urandom_range(0, 1000000),
                           $urandom_range(0, 1000000), $urandom_range(0, 1000))};
      end else begin
         for (int i = 0; i < 5; i++) begin
            case ($urandom_range(0, 3))
               0: p = {p, ",65536"};
               1: p = {p, ",1000001"};
               2: p = {p, ",1001"};
               default: p = {p, ",", rand_number()};
            endcase
         end
      end
      return p;
   endfunction

   function string random_payload();
      string p;
      case ($urandom_range(0, 9))
         0, 1: p = {"ARM,", ($urandom_range(0, 2) == 0) ? "0" : rand_number()};
         2, 3: p = {"PING,", rand_number()};
         4, 5, 6: p = shot_payload($urandom_range(0, 4) != 0);
         7: p = {"SHOT,", rand_number(), ",1,2"};
         8: p = {"PING,", rand_number(), "x"};
         default: p = {"SHOX,", rand_number()};
      endcase
      // collapsing empty tokens
      if ($urandom_range(0, 4) == 0) p = {",", p, ",,"};
      return p;
   endfunction

   // frame with some random damage: a stray byte, a bad or malformed checksum, a zero byte or junk
   function string broken_line(string payload);
      string f;
      int pos;
      f = frame(payload);
      case ($urandom_range(0, 4))
         0: begin
            pos = $urandom_range(1, f.len() - 2);
            f[pos] = 8'($urandom_range(1, 255));
            if (f[pos] == CH_LF) f[pos] = 8'hFF;
         end
         1: f = {"$", payload, "*", hex_pair(xor_of(payload) ^ 8'($urandom_range(1, 255))), "\n"};
         2: f = {"$", payload, "*", string'(8'($urandom_range(128, 255))), "0\n"};
         3: begin
            f = "";
            for (int i = 0; i < $urandom_range(1, 20); i++)
               f = {f, string'(8'($urandom_range(1, 255)))};
            f = {f, "\n"};
         end
         default: f = {"$", payload, string'(8'h00), "*00\n"};
      endcase
      return f;
   endfunction

   function string overflow_line();
      string f;
      f = "$PING,";
      while (f.len() < LINE_MAX + 3) f = {f, "7"};
      return {f, "\n"};
   endfunction

   task drain();
      req_tvalid <= 0;
      while (expected.outstanding.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      result_type got;
      int stall;
      rsp_tready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         stall = pick_gap();
         rsp_tready <= (stall == 0);
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = '0;
            got.is_error = rsp_tuser;
            got.error_code = err_type'(rsp_tdata[3:0]);
            got.seq = rsp_tdata[35:4];
            got.shot_go = rsp_tdata[36];
            got.dac_x = rsp_tdata[52:37];
            got.dac_y = rsp_tdata[68:53];
            got.settle_delay = rsp_tdata[88:69];
            got.fire_us = rsp_tdata[108:89];
            got.power_level = rsp_tdata[118:109];
            expected.check_result(got);
         end
         if (stall > 0) begin
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      expected = new();
      expected.reset_all();
      hold_off = 0;
      bytes_sent = 0;
      lines_sent = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed lines
      send_text(frame("PING,0"));
      send_text(frame("SHOT,3,1,2,3,4,5"));
      send_text(frame("ARM,1"));
      send_text(frame("SHOT,7,65535,0,1000000,0,1000"));
      send_text(frame("SHOT,8,65536,0,0,0,0"));
      send_text(frame(",,PING,,4294967295,"));
      send_text(frame("PING,99999999999"));
      send_text(frame("ARM"));
      send_text(frame("PING,1a"));
      send_text(frame("SHOT,1,2"));
      send_text(frame("SHOT,1,2,3,4,5,z"));
      send_text(frame("FIRE,1"));
      send_text(frame(",,,"));
      send_text("$*00\n");
      send_text("$PING,1\r\n");
      send_text({"$PING,2*", hex_pair(xor_of("PING,2") ^ 8'h5A), "\n"});
      send_text("$PING,2*G1\n");
      // a zero byte hides the rest of the line from the parser
      send_text("$ARM,5");
      send_byte(CH_NUL);
      send_text("zz*00\n");
      send_text({"hello", string'(8'hFF), string'(8'h80), "\n"});
      send_text("\r\n\n");
      send_text(overflow_line());
      send_text(frame("ARM,0"));
      send_text(frame("SHOT,9,1,1,1,1,1"));
      drain();

      // random part; a long receiver hold-off and a full drain along the way
      while (bytes_sent < 1150) begin
         if (lines_sent == 30) begin
            hold_off = 1;
            for (int i = 0; i < 12; i++) send_text(frame(random_payload()));
         end
         if (lines_sent == 45) drain();
         case ($urandom_range(0, 19))
            0, 1, 2: send_text(broken_line(random_payload()));
            3: send_text(overflow_line());
            4: send_text(frame("ARM,1"));
            default: send_text(frame(random_payload()));
         endcase
      end
      req_tvalid <= 0;
      while (expected.outstanding.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d bytes in %0d lines, checked %0d results, %0d shot orders",
               bytes_sent, lines_sent, expected.checked, expected.shots_fired);
      if (expected.mismatches == 0 && expected.outstanding.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
